// ----- rtl/core/nal_pkg.sv -----
// ----------------------------------------------------------------------------
// NUMA-aware lock arbiter package
// Shared item types, controller/datapath interface structs and constants.
// ----------------------------------------------------------------------------
package nal_pkg;

  typedef struct packed {
    logic       req_type;
    logic [3:0] requester_id;
    logic [1:0] socket_id;
  } in_item_t;

  typedef struct packed {
    logic       grant_valid;
    logic [3:0] grant_id;
    logic       from_secondary;
    logic       overflow_error;
  } out_item_t;

  typedef struct packed {
    logic [3:0] id;
    logic [1:0] sock;
  } entry_t;

  typedef struct packed {
    logic load;
    logic acq;
    logic free;
    logic rng_step;
    logic scan;
    logic sec_grant;
    logic head_grant;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rel;
    logic holder_valid;
    logic main_empty;
    logic sec_empty;
    logic hit;
    logic last;
  } dp_stat_t;

  localparam int          PADDR_W        = 3;
  localparam int          PDATA_W        = 32;
  localparam logic        REQ_ACQUIRE    = 1'b0;
  localparam logic        REQ_RELEASE    = 1'b1;
  localparam logic        REG_RNG_SEED   = 1'b0;
  localparam logic        REG_FLUSH_MASK = 1'b1;
  localparam logic [31:0] RNG_SEED_RST   = 32'd1;
  localparam logic [15:0] FLUSH_MASK_RST = 16'd1023;

  function automatic logic [31:0] rng_next(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v << 6);
    t = t ^ (t >> 21);
    t = t ^ (t << 7);
    return t;
  endfunction

endpackage

// ----- rtl/core/nal_ctrl.sv -----
// ----------------------------------------------------------------------------
// NUMA-aware lock arbiter controller
// Sequences one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module nal_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  nal_pkg::dp_stat_t stat,
  output nal_pkg::dp_cmd_t  cmd
);
  import nal_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_MRD, S_MCHK, S_SRD, S_SGRANT, S_HGRANT, S_FIN
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_DECIDE: begin
        if (!stat.is_rel) begin
          cmd.acq = 1'b1;
        end else if (stat.holder_valid && stat.main_empty && stat.sec_empty) begin
          cmd.free = 1'b1;
        end else if (stat.holder_valid && !stat.main_empty) begin
          cmd.rng_step = 1'b1;
        end
      end
      S_MCHK:   cmd.scan = 1'b1;
      S_SGRANT: cmd.sec_grant = 1'b1;
      S_HGRANT: cmd.head_grant = 1'b1;
      S_FIN:    cmd.push = slot_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_FIN && slot_free) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!stat.is_rel || !stat.holder_valid) begin
            state <= S_FIN;
          end else if (stat.main_empty) begin
            state <= stat.sec_empty ? S_FIN : S_SRD;
          end else begin
            state <= S_MRD;
          end
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (stat.hit) begin
            state <= S_FIN;
          end else if (stat.last) begin
            state <= stat.sec_empty ? S_HGRANT : S_SRD;
          end else begin
            state <= S_MRD;
          end
        end
        S_SRD:    state <= S_SGRANT;
        S_SGRANT: state <= S_FIN;
        S_HGRANT: state <= S_FIN;
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fin_push: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && slot_free) |=> out_valid)
    else $error("finished result not presented");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_ready && !cmd.scan && !cmd.push))
    else $error("load outside idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped before acceptance");

endmodule

// ----- rtl/core/nal_dp.sv -----
// ----------------------------------------------------------------------------
// NUMA-aware lock arbiter datapath
// Queue memories, pointers, generator, register port and result registers.
// ----------------------------------------------------------------------------
module nal_dp #(
  parameter int MAX_REQUESTERS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nal_pkg::in_item_t             in_data,
  output nal_pkg::out_item_t            out_data,
  input  nal_pkg::dp_cmd_t              cmd,
  output nal_pkg::dp_stat_t             stat,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nal_pkg::PADDR_W-1:0]   paddr,
  input  logic [nal_pkg::PDATA_W-1:0]   pwdata,
  output logic [nal_pkg::PDATA_W-1:0]   prdata
);
  import nal_pkg::*;

  localparam int AW = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int CW = $clog2(MAX_REQUESTERS + 1);
  localparam logic [AW:0] MAXV = (AW + 1)'(MAX_REQUESTERS);
  localparam logic [CW:0] MAXC = (CW + 1)'(MAX_REQUESTERS);

  function automatic logic [AW-1:0] wrap(input logic [AW:0] x);
    return (x >= MAXV) ? AW'(x - MAXV) : AW'(x);
  endfunction

  entry_t     mem_a [MAX_REQUESTERS];
  entry_t     mem_b [MAX_REQUESTERS];
  entry_t     rd_a, rd_b, main_rd, sec_rd, first;
  in_item_t   req;
  out_item_t  res;
  logic          holder_valid, sel, local_r;
  logic [1:0]    holder_socket;
  logic [AW-1:0] mhead, shead, idx;
  logic [CW-1:0] mcount, scount;
  logic [31:0]   rng_state, rng_seed, rng_nxt;
  logic [15:0]   flush_mask;
  logic [AW-1:0] main_raddr, main_waddr, sec_waddr;
  logic          wr_main, wr_sec, we_a, we_b, cfg_we, full;
  entry_t        wdata_main, wdata_sec, wdata_a, wdata_b;

  assign main_rd   = sel ? rd_b : rd_a;
  assign sec_rd    = sel ? rd_a : rd_b;
  assign main_raddr = wrap((AW + 1)'(mhead) + (AW + 1)'(idx));
  assign main_waddr = wrap((AW + 1)'(mhead) + (AW + 1)'(mcount));
  assign sec_waddr  = wrap((AW + 1)'(shead) + (AW + 1)'(scount) + (AW + 1)'(idx));
  assign full    = ((CW + 1)'(mcount) + (CW + 1)'(scount)) >= MAXC;
  assign rng_nxt = rng_next(rng_state);

  assign stat.is_rel       = (req.req_type == REQ_RELEASE);
  assign stat.holder_valid = holder_valid;
  assign stat.main_empty   = (mcount == '0);
  assign stat.sec_empty    = (scount == '0);
  assign stat.hit          = local_r && (main_rd.sock == holder_socket);
  assign stat.last         = ((CW)'(idx) + CW'(1)) == mcount;

  assign wr_main    = cmd.acq && holder_valid && !full;
  assign wr_sec     = cmd.scan && !stat.hit;
  assign wdata_main = '{id: req.requester_id, sock: req.socket_id};
  assign wdata_sec  = main_rd;
  assign we_a    = sel ? wr_sec : wr_main;
  assign we_b    = sel ? wr_main : wr_sec;
  assign wdata_a = sel ? wdata_sec : wdata_main;
  assign wdata_b = sel ? wdata_main : wdata_sec;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[sel ? sec_waddr : main_waddr] <= wdata_a;
    end
    if (we_b) begin
      mem_b[sel ? main_waddr : sec_waddr] <= wdata_b;
    end
    rd_a <= mem_a[sel ? shead : main_raddr];
    rd_b <= mem_b[sel ? main_raddr : shead];
  end

  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_RNG_SEED) ? rng_seed : {16'd0, flush_mask};

  always_ff @(posedge clk) begin
    if (rst) begin
      holder_valid  <= 1'b0;
      holder_socket <= '0;
      sel           <= 1'b0;
      mhead         <= '0;
      shead         <= '0;
      mcount        <= '0;
      scount        <= '0;
      rng_seed      <= RNG_SEED_RST;
      rng_state     <= RNG_SEED_RST;
      flush_mask    <= FLUSH_MASK_RST;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_RNG_SEED) begin
          rng_seed  <= pwdata;
          rng_state <= pwdata;
        end else begin
          flush_mask <= pwdata[15:0];
        end
      end
      if (cmd.load) begin
        req <= in_data;
        res <= '0;
        idx <= '0;
      end
      if (cmd.acq) begin
        if (!holder_valid) begin
          holder_valid  <= 1'b1;
          holder_socket <= req.socket_id;
          res.grant_valid <= 1'b1;
          res.grant_id    <= req.requester_id;
        end else if (full) begin
          res.overflow_error <= 1'b1;
        end else begin
          mcount <= mcount + CW'(1);
        end
      end
      if (cmd.free) begin
        holder_valid <= 1'b0;
      end
      if (cmd.rng_step) begin
        rng_state <= rng_nxt;
        local_r   <= (rng_nxt[15:0] & flush_mask) != '0;
      end
      if (cmd.scan) begin
        if (idx == '0) begin
          first <= main_rd;
        end
        if (stat.hit) begin
          res.grant_valid <= 1'b1;
          res.grant_id    <= main_rd.id;
          holder_socket   <= main_rd.sock;
          scount <= scount + CW'(idx);
          mhead  <= wrap((AW + 1)'(mhead) + (AW + 1)'(idx) + (AW + 1)'(1));
          mcount <= mcount - CW'(idx) - CW'(1);
        end else begin
          idx <= idx + AW'(1);
        end
      end
      if (cmd.head_grant) begin
        res.grant_valid <= 1'b1;
        res.grant_id    <= first.id;
        holder_socket   <= first.sock;
        mhead  <= wrap((AW + 1)'(mhead) + (AW + 1)'(1));
        mcount <= mcount - CW'(1);
      end
      if (cmd.sec_grant) begin
        res.grant_valid    <= 1'b1;
        res.grant_id       <= sec_rd.id;
        res.from_secondary <= 1'b1;
        holder_socket      <= sec_rd.sock;
        sel    <= ~sel;
        mhead  <= wrap((AW + 1)'(shead) + (AW + 1)'(1));
        mcount <= scount - CW'(1) + mcount;
        shead  <= mhead;
        scount <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= res;
    end
  end

  a_total: assert property (@(posedge clk) disable iff (rst)
    ((CW + 1)'(mcount) + (CW + 1)'(scount)) <= MAXC)
    else $error("queue occupancy above capacity");

  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    !holder_valid |-> (mcount == '0 && scount == '0))
    else $error("waiters queued on a free lock");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (CW'(idx) < mcount))
    else $error("scan index past main queue");

endmodule

// ----- rtl/core/numa_aware_lock_arbiter_core.sv -----
// ----------------------------------------------------------------------------
// NUMA-aware lock arbiter core
// Single-lock manager with main and secondary waiter queues and locality
// preferring handover, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Sequencing: an acquire or a release without waiters goes from accept through
// the decide and finish states to the result; a release with main-queue waiters
// also scans the main queue, reading and checking each entry in turn.
// Throughput: one item at a time; the next beat is taken only once the previous
// result has been pushed to the output, which waits while the output stalls.
// Reset: synchronous; the lock is free, both queues empty, registers at reset.
module numa_aware_lock_arbiter_core #(
  parameter int MAX_REQUESTERS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  nal_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nal_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nal_pkg::PADDR_W-1:0]   paddr,
  input  logic [nal_pkg::PDATA_W-1:0]   pwdata,
  output logic [nal_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import nal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready = 1'b1;

  nal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nal_dp #(
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule
